### hw/rtl/pl3_pkg.sv
// Package with shared widths, constants and controller/datapath link types.
`timescale 1ns / 1ps
package pl3_pkg;

    // Fixed result field widths
    localparam int SEG_W   = 25;
    localparam int TOTAL_W = 40;

    // Saturation ceiling of the running total
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Last count of the squaring sequence (three squares plus one drain step)
    localparam int SQ_LAST = 3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a point
        logic square;     // multiply one difference, shift the rest
        logic sq_acc;     // add the previous product into the sum
        logic root_init;  // seed the square root unit
        logic root_step;  // one result bit of the square root
        logic accum;      // saturating add into the total
        logic out_write;  // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic start_pt;   // offered point opens a new polyline
        logic out_free;   // output register can take a new result
    } t_status;

endpackage

### hw/rtl/pl3_if.sv
// Point and result channel interfaces.
`timescale 1ns / 1ps
interface pl3_in_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         first_point;
    logic                         last_point;

    modport source (output valid, coord_x, coord_y, coord_z, first_point, last_point,
                    input ready);
    modport sink (input valid, coord_x, coord_y, coord_z, first_point, last_point,
                  output ready);
endinterface

interface pl3_out_if import pl3_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SEG_W-1:0]   segment_length;
    logic [TOTAL_W-1:0] total_length;
    logic               path_end;

    modport source (output valid, segment_length, total_length, path_end, input ready);
    modport sink (input valid, segment_length, total_length, path_end, output ready);
endinterface

### hw/rtl/pl3_datapath.sv
// Datapath: point differences, shared squarer, restoring square root, total.
`timescale 1ns / 1ps
module pl3_datapath import pl3_pkg::*; #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  logic                         i_first_point,
    input  logic                         i_last_point,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [SEG_W-1:0]             o_segment_length,
    output logic [TOTAL_W-1:0]           o_total_length,
    output logic                         o_path_end
);

    localparam int CW    = COORD_BITS;
    localparam int PW    = 2 * CW;
    localparam int SW    = PW + 2;
    localparam int RAD_W = SW + 2 * FRACTION_BITS;
    localparam int RW    = RAD_W / 2;
    localparam int REM_W = RW + 2;
    localparam int AW    = ((RW > TOTAL_W) ? RW : TOTAL_W) + 1;

    logic signed [CW-1:0] r_prev [3];
    logic        [CW-1:0] r_diff [3];
    logic                 r_have_prev;
    logic                 r_last;
    logic [PW-1:0]        r_prod;
    logic [SW-1:0]        r_sum;
    logic [RAD_W-1:0]     r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [RW-1:0]        r_root;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_out_valid;
    logic [SEG_W-1:0]     r_seg;
    logic [TOTAL_W-1:0]   r_tot_out;
    logic                 r_end;

    logic signed [CW-1:0] w_coord [3];
    logic        [CW-1:0] w_abs   [3];
    logic        [CW:0]   w_sub   [3];
    logic [PW-1:0]        w_sq;
    logic [REM_W-1:0]     w_rem_sh;
    logic [REM_W-1:0]     w_trial;
    logic                 w_fit;
    logic [AW-1:0]        w_add;
    logic [63:0]          w_root_ext;

    assign w_coord[0] = i_coord_x;
    assign w_coord[1] = i_coord_y;
    assign w_coord[2] = i_coord_z;

    // Absolute difference to the previous point, per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sub[a] = {w_coord[a][CW-1], w_coord[a]} - {r_prev[a][CW-1], r_prev[a]};
            w_abs[a] = w_sub[a][CW] ? CW'(-w_sub[a]) : w_sub[a][CW-1:0];
        end
    end

    assign w_sq = r_diff[0] * r_diff[0];

    // Restoring square root: bring down two radicand bits, try root*4+1
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    // Saturating total update
    assign w_add      = AW'(r_total) + AW'(r_root);
    assign w_root_ext = 64'(r_root);

    assign o_status.start_pt = i_first_point | ~r_have_prev;
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    // Point state and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= '0;
            end
            r_have_prev <= 1'b0;
            r_total     <= '0;
        end else begin
            if (i_cmd.load) begin
                for (int a = 0; a < 3; a++) begin
                    r_prev[a] <= w_coord[a];
                end
                r_have_prev <= ~i_last_point;
                if (o_status.start_pt) begin
                    r_total <= '0;
                end
            end
            if (i_cmd.accum) begin
                r_total <= (w_add > AW'(TOTAL_MAX)) ? TOTAL_MAX : w_add[TOTAL_W-1:0];
            end
        end
    end

    // Squaring and square root payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < 3; a++) begin
                r_diff[a] <= w_abs[a];
            end
            r_last <= i_last_point;
            r_root <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.square) begin
            r_prod    <= w_sq;
            r_diff[0] <= r_diff[1];
            r_diff[1] <= r_diff[2];
            r_sum     <= i_cmd.sq_acc ? (r_sum + SW'(r_prod)) : '0;
        end
        if (i_cmd.root_init) begin
            r_rad  <= RAD_W'(r_sum) << (2 * FRACTION_BITS);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[RW-2:0], w_fit};
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_seg     <= w_root_ext[SEG_W-1:0];
            r_tot_out <= r_total;
            r_end     <= r_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_segment_length = r_seg;
    assign o_total_length   = r_tot_out;
    assign o_path_end       = r_end;

endmodule

### hw/rtl/pl3_ctrl.sv
// Controller: sequences capture, squaring, square root, accumulation and output.
`timescale 1ns / 1ps
module pl3_ctrl import pl3_pkg::*; #(
    parameter int ROOT_BITS = 25
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(ROOT_BITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SQ    = 6'b000010,
        S_RINIT = 6'b000100,
        S_ROOT  = 6'b001000,
        S_ACCUM = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Next state and step count
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.start_pt ? S_DONE : S_SQ;
                    n_cnt   = '0;
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_LAST)) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                n_state = S_ROOT;
                n_cnt   = '0;
            end
            S_ROOT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_BITS - 1)) begin
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Decode commands from the state
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) & i_in_valid;
    assign o_cmd.square    = (r_state == S_SQ);
    assign o_cmd.sq_acc    = (r_state == S_SQ) & (r_cnt != '0);
    assign o_cmd.root_init = (r_state == S_RINIT);
    assign o_cmd.root_step = (r_state == S_ROOT);
    assign o_cmd.accum     = (r_state == S_ACCUM);
    assign o_cmd.out_write = (r_state == S_DONE) & i_status.out_free;

endmodule

### hw/rtl/polyline_length_3d.sv
// Sequence: a point that opens a polyline goes straight to the output register; any
// other point passes through squaring, root seeding, the square root (one root bit per
// cycle), accumulation and output. Only one point is in flight: the next point is
// taken only once the result has been written, and a result held back by the sink
// stalls the next point.
// Reset (synchronous, active low) clears the controller, output valid, previous point and total.
`timescale 1ns / 1ps
module polyline_length_3d import pl3_pkg::*; #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pl3_in_if.sink         i_point,
    pl3_out_if.source      o_result
);

    localparam int ROOT_BITS = COORD_BITS + 1 + FRACTION_BITS;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    pl3_ctrl #(
        .ROOT_BITS (ROOT_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_point.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pl3_datapath #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_coord_x        (i_point.coord_x),
        .i_coord_y        (i_point.coord_y),
        .i_coord_z        (i_point.coord_z),
        .i_first_point    (i_point.first_point),
        .i_last_point     (i_point.last_point),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_segment_length (o_result.segment_length),
        .o_total_length   (o_result.total_length),
        .o_path_end       (o_result.path_end)
    );

    assign i_point.ready = w_in_ready;

    // One point in flight: no acceptance in the cycle after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_point.valid && i_point.ready) |=> !i_point.ready)
        else $error("point accepted while another is in flight");

    // The total always covers the segment it includes
    a_total_covers_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.total_length >= TOTAL_W'(o_result.segment_length)))
        else $error("total below segment length");

    // A result appears only from an output write
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_cmd.out_write))
        else $error("result valid without output write");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the 3D polyline length block.
`timescale 1ns / 1ps
module tb_top import pl3_pkg::*; ();

    localparam int COORD_BITS     = 16;
    localparam int FRAC_BITS      = 8;
    localparam int RANDOM_POINTS  = 1460;
    // Length of the path made only of maximum-length segments
    localparam int MAX_SEG_POINTS = 40;
    localparam int DRAIN_CYCLES   = 64;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   opens;
        logic   closes;
    } t_point;

    typedef struct packed {
        logic [SEG_W-1:0]   seg;
        logic [TOTAL_W-1:0] total;
        logic               path_end;
    } t_path_result;

    typedef enum int {
        STYLE_FULL,
        STYLE_NEAR,
        STYLE_EXTREME,
        STYLE_SMALL,
        STYLE_AXIS
    } t_coord_style;

    logic clk;
    logic rst_n;

    pl3_in_if #(.COORD_BITS(COORD_BITS)) point_if ();
    pl3_out_if                           result_if ();

    polyline_length_3d #(
        .COORD_BITS   (COORD_BITS),
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_point (point_if),
        .o_result(result_if)
    );

    // Path state of the predictor
    t_coord             last_x;
    t_coord             last_y;
    t_coord             last_z;
    logic [TOTAL_W-1:0] path_total;
    bit                 path_open;

    t_path_result expected_lengths[$];

    // Sender and receiver pacing controls
    bit gaps_on;
    int burst_left;
    bit rx_stalls_on;
    int rx_hold;

    int points_sent     = 0;
    int results_checked = 0;
    int paths_closed    = 0;
    int saturated_hits  = 0;
    int error_count     = 0;

    // Generate the clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run in time
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // floor(sqrt(sq) * 2^FRAC_BITS), one result bit at a time from the top
    function automatic logic [SEG_W-1:0] fixed_root(input longint unsigned sq);
        longint unsigned scaled;
        longint unsigned root;
        longint unsigned cand;
        scaled = sq << (2 * FRAC_BITS);
        root   = 0;
        for (int b = SEG_W; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= scaled) root = cand;
        end
        return root[SEG_W-1:0];
    endfunction

    // Advance the path state by one point and return the result it produces
    function automatic t_path_result predict_path(input t_point p);
        t_path_result    r;
        longint          dx;
        longint          dy;
        longint          dz;
        longint unsigned dist_sq;
        logic [SEG_W-1:0] seg;
        seg = '0;
        if (p.opens || !path_open) begin
            path_total = '0;
        end else begin
            dx = longint'(signed'(p.x)) - longint'(signed'(last_x));
            dy = longint'(signed'(p.y)) - longint'(signed'(last_y));
            dz = longint'(signed'(p.z)) - longint'(signed'(last_z));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            dist_sq = dx * dx + dy * dy + dz * dz;
            seg     = fixed_root(dist_sq);
            // Saturate the total at its ceiling
            if (path_total > TOTAL_MAX - TOTAL_W'(seg)) path_total = TOTAL_MAX;
            else path_total = path_total + TOTAL_W'(seg);
        end
        last_x    = p.x;
        last_y    = p.y;
        last_z    = p.z;
        path_open = !p.closes;
        r.seg      = seg;
        r.total    = path_total;
        r.path_end = p.closes;
        return r;
    endfunction

    function automatic t_point mk_point(input int x, input int y, input int z,
                                       input bit opens, input bit closes);
        t_point p;
        p.x      = t_coord'(x);
        p.y      = t_coord'(y);
        p.z      = t_coord'(z);
        p.opens  = opens;
        p.closes = closes;
        return p;
    endfunction

    function automatic t_coord pick_coord(input t_coord prev, input t_coord_style style);
        t_coord step;
        case (style)
            STYLE_NEAR: begin
                step = t_coord'($urandom_range(0, 40));
                return prev + step - t_coord'(20);
            end
            STYLE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MIN;
                    1:       return t_coord'(-1);
                    2:       return t_coord'(0);
                    3:       return t_coord'(1);
                    default: return COORD_MAX;
                endcase
            end
            STYLE_SMALL: begin
                step = t_coord'($urandom_range(0, 8));
                return step - t_coord'(4);
            end
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Offer one point, hold it until the transaction completes, record its result
    task automatic send_point(input t_point p);
        point_if.valid       <= 1'b1;
        point_if.coord_x     <= p.x;
        point_if.coord_y     <= p.y;
        point_if.coord_z     <= p.z;
        point_if.first_point <= p.opens;
        point_if.last_point  <= p.closes;
        @(posedge clk);
        while (!point_if.ready) @(posedge clk);
        expected_lengths.push_back(predict_path(p));
        points_sent++;
        @(negedge clk);
    endtask

    // Insert a random gap at the end of a burst
    task automatic pace_sender();
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                point_if.valid <= 1'b0;
                repeat ($urandom_range(1, 45)) @(negedge clk);
                burst_left = $urandom_range(0, 8);
            end
        end
    endtask

    // Drive result ready: forced hold-off first, then always ready, or alternating runs and stalls when stalls are on
    initial begin : result_receiver
        int run_left;
        bit stalled;
        bit next_ready;
        run_left        = 0;
        stalled         = 1'b0;
        result_if.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                next_ready = 1'b0;
                rx_hold--;
            end else if (!rx_stalls_on) begin
                next_ready = 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalled  = !stalled;
                    run_left = stalled ? $urandom_range(1, 20) : $urandom_range(1, 60);
                end
                run_left--;
                next_ready = !stalled;
            end
            result_if.ready <= next_ready;
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk) begin : result_check
        t_path_result want;
        t_path_result got;
        if (rst_n && result_if.valid && result_if.ready) begin
            got.seg      = result_if.segment_length;
            got.total    = result_if.total_length;
            got.path_end = result_if.path_end;
            if (expected_lengths.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected result seg=%0d total=%0d end=%0b",
                             got.seg, got.total, got.path_end);
            end else begin
                want = expected_lengths.pop_front();
                results_checked++;
                if (got.seg !== want.seg || got.total !== want.total ||
                    got.path_end !== want.path_end) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: result %0d want %0d/%0d/%0b got %0d/%0d/%0b",
                                 results_checked, want.seg, want.total, want.path_end,
                                 got.seg, got.total, got.path_end);
                end
                if (got.total == TOTAL_MAX) saturated_hits++;
                if (got.path_end) paths_closed++;
            end
        end
    end

    // Field extremes, flag combinations and path boundaries
    task automatic test_directed_cases();
        rx_stalls_on = 1'b1;
        gaps_on      = 1'b0;
        // no previous point after reset: opens a path even without the flag
        send_point(mk_point(5, 5, 5, 1'b0, 1'b0));
        send_point(mk_point(8, 9, 5, 1'b0, 1'b0));
        // zero-length segment
        send_point(mk_point(8, 9, 5, 1'b0, 1'b0));
        // irrational distance, truncated
        send_point(mk_point(9, 10, 6, 1'b0, 1'b0));
        send_point(mk_point(-32768, -32768, -32768, 1'b0, 1'b0));
        // longest possible segment
        send_point(mk_point(32767, 32767, 32767, 1'b0, 1'b0));
        send_point(mk_point(32767, -32768, 0, 1'b0, 1'b0));
        // restart in the middle of a path
        send_point(mk_point(0, 0, 0, 1'b1, 1'b0));
        send_point(mk_point(0, 0, -1, 1'b0, 1'b1));
        // point after a closed path opens a new one
        send_point(mk_point(100, 0, 0, 1'b0, 1'b0));
        // both flags at once
        send_point(mk_point(0, 0, 0, 1'b1, 1'b1));
        send_point(mk_point(7, 7, 7, 1'b0, 1'b1));
        send_point(mk_point(-1, -1, -1, 1'b1, 1'b0));
        send_point(mk_point(0, -32768, 32767, 1'b0, 1'b0));
        send_point(mk_point(32767, 0, -32768, 1'b0, 1'b1));
        // one axis at a time across the full range
        send_point(mk_point(-32768, 0, 0, 1'b1, 1'b0));
        send_point(mk_point(32767, 0, 0, 1'b0, 1'b0));
        send_point(mk_point(32767, 32767, 0, 1'b0, 1'b0));
        send_point(mk_point(32767, 32767, 32767, 1'b0, 1'b1));
        point_if.valid <= 1'b0;
    endtask

    // Hold off the receiver while points keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        t_point p;
        p       = '0;
        gaps_on = 1'b0;
        rx_hold = 300;
        for (int k = 0; k < 24; k++) begin
            p.x      = pick_coord(p.x, STYLE_FULL);
            p.y      = pick_coord(p.y, STYLE_NEAR);
            p.z      = pick_coord(p.z, STYLE_SMALL);
            p.opens  = (k == 0);
            p.closes = (k == 23);
            send_point(p);
        end
        point_if.valid <= 1'b0;
    endtask

    // Mostly well-formed paths with random content, some broken paths and noise
    task automatic test_random_paths(input int n_points);
        t_point       p;
        t_coord_style style;
        int           sent;
        int           len;
        bit           broken;
        p            = '0;
        sent         = 0;
        burst_left   = 0;
        rx_stalls_on = 1'b1;
        while (sent < n_points) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                p.x      = pick_coord(p.x, STYLE_FULL);
                p.y      = pick_coord(p.y, STYLE_FULL);
                p.z      = pick_coord(p.z, STYLE_FULL);
                p.opens  = 1'($urandom_range(0, 1));
                p.closes = 1'($urandom_range(0, 1));
                send_point(p);
                pace_sender();
                sent++;
            end else begin
                len    = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
                style  = t_coord_style'($urandom_range(0, 4));
                broken = ($urandom_range(0, 7) == 0);
                for (int k = 0; k < len; k++) begin
                    if (style == STYLE_AXIS) begin
                        case ($urandom_range(0, 2))
                            0:       p.x = pick_coord(p.x, STYLE_FULL);
                            1:       p.y = pick_coord(p.y, STYLE_FULL);
                            default: p.z = pick_coord(p.z, STYLE_FULL);
                        endcase
                    end else begin
                        p.x = pick_coord(p.x, style);
                        p.y = pick_coord(p.y, style);
                        p.z = pick_coord(p.z, style);
                    end
                    p.opens  = (k == 0) ? ($urandom_range(0, 3) != 0) : 1'b0;
                    p.closes = (k == len - 1) && !broken;
                    send_point(p);
                    pace_sender();
                    sent++;
                end
            end
        end
        point_if.valid <= 1'b0;
    endtask

    // Drive one path of maximum-length segments back to back
    task automatic test_max_segment_path();
        t_point p;
        p            = '0;
        gaps_on      = 1'b0;
        rx_stalls_on = 1'b0;
        for (int k = 0; k < MAX_SEG_POINTS; k++) begin
            p.x      = k[0] ? COORD_MAX : COORD_MIN;
            p.y      = p.x;
            p.z      = p.x;
            p.opens  = (k == 0);
            p.closes = 1'b0;
            send_point(p);
        end
        // close the long path, then confirm the next one starts from zero
        send_point(mk_point(0, 0, 0, 1'b0, 1'b1));
        send_point(mk_point(0, 0, 0, 1'b1, 1'b0));
        send_point(mk_point(3, 4, 0, 1'b0, 1'b1));
        point_if.valid <= 1'b0;
    endtask

    initial begin
        rst_n                = 1'b0;
        point_if.valid       = 1'b0;
        point_if.coord_x     = '0;
        point_if.coord_y     = '0;
        point_if.coord_z     = '0;
        point_if.first_point = 1'b0;
        point_if.last_point  = 1'b0;
        last_x               = '0;
        last_y               = '0;
        last_z               = '0;
        path_total           = '0;
        path_open            = 1'b0;
        gaps_on              = 1'b0;
        burst_left           = 0;
        rx_stalls_on         = 1'b0;
        rx_hold              = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_random_paths(RANDOM_POINTS);
        test_max_segment_path();

        // Drain the pipeline
        while (expected_lengths.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d points over directed, stall, random and long-segment runs;",
                 points_sent);
        $display("checked %0d results, %0d closed paths, %0d pinned totals, %0d errors.",
                 results_checked, paths_closed, saturated_hits, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
